// ----- rtl/rrsa_pkg.sv -----
// Shared types and constants of the round-robin slot allocator.
`default_nettype none

package rrsa_pkg;

    // Slots the allocator is built for; the busy map holds at most 32 of them.
    localparam int NUM_SLOTS  = 32;
    localparam int PHYS_SLOTS = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;

    localparam int MAP_W   = 32;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    typedef logic [MAP_W-1:0]   map_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_GRANTED     = 2'd0,
        ST_ALL_BUSY    = 2'd1,
        ST_RELEASED    = 2'd2,
        ST_BAD_RELEASE = 2'd3
    } status_t;

    // Register index taken from paddr[2]
    localparam logic REG_QUEUE_DEPTH = 1'b0;

    localparam count_t DEPTH_RESET = COUNT_W'(PHYS_SLOTS);

    // Index of the lowest set bit, zero when none is set.
    function automatic slot_t lowest_set(input map_t vec);
        slot_t idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rrsa_req_if.sv -----
// Request channel of the slot allocator: opcode and slot to release.
`default_nettype none

interface rrsa_req_if
    import rrsa_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  opcode;
    slot_t release_slot;

    modport source (output valid, output opcode, output release_slot, input ready);
    modport sink   (input valid, input opcode, input release_slot, output ready);
endinterface

`default_nettype wire

// ----- rtl/rrsa_rsp_if.sv -----
// Response channel of the slot allocator: status, granted slot, busy count.
`default_nettype none

interface rrsa_rsp_if
    import rrsa_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    slot_t      slot;
    count_t     outstanding;

    modport source (output valid, output status, output slot, output outstanding,
                    input ready);
    modport sink   (input valid, input status, input slot, input outstanding,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/round_robin_slot_allocator_top.sv -----
// Round-robin slot allocator: busy bitmap, rotating scan pointer, APB depth register.
//
// Usage: each request beat on req carries an opcode (allocate or release) and a
// slot number for release. Every request yields exactly one response beat on rsp
// with a status, the granted slot (zero unless granted) and the busy count.
// A beat is taken at a clock edge with valid and ready both high.
// A request beat that is taken is loaded into the input register and passes from
// there through the scan logic into the response register, where it is valid.
// Throughput is one request per cycle while the response is not stalled and no
// depth write is being processed; the scan over up to 32 slots is a single
// priority search, and the busy map is updated in the same cycle.
// The APB register queue_depth sets how many slots are scanned. After a write
// the start pointer is reduced modulo the new depth by repeated subtraction,
// during which req.ready stays low.
// At reset all slots are free, the pointer is zero and the depth is 32.
// When the receiver stalls, the response register holds its beat and one more
// request waits in the input register; req.ready then drops.
`default_nettype none

module round_robin_slot_allocator_top
    import rrsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rrsa_req_if.sink               req,
    rrsa_rsp_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // Configuration and state
    count_t  depth_reg,       depth_next;
    map_t    busy_map_reg,    busy_map_next;
    slot_t   scan_start_reg,  scan_start_next;
    slot_t   start_mod_reg,   start_mod_next;
    logic    norm_busy_reg,   norm_busy_next;
    count_t  busy_count_reg,  busy_count_next;

    // Input stage
    logic    stage_valid_reg, stage_valid_next;
    logic    stage_op_reg;
    slot_t   stage_rel_reg;

    // Response register
    logic    rsp_valid_reg,   rsp_valid_next;
    status_t status_reg,      status_next;
    slot_t   slot_reg,        slot_next;
    count_t  outstanding_reg;

    logic    cfg_write;
    logic    req_take;
    logic    advance;
    count_t  eff_depth;
    map_t    depth_mask;
    map_t    start_mask;
    map_t    free_map;
    map_t    upper_free;
    slot_t   pick;
    count_t  pick_inc;
    logic    rel_ok;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_QUEUE_DEPTH)
                       ? {{(DATA_W-COUNT_W){1'b0}}, depth_reg} : '0;

    // Clamp the depth to 1 .. PHYS_SLOTS
    always_comb
    begin
        if (depth_reg == '0)
        begin
            eff_depth = COUNT_W'(1);
        end
        else if (depth_reg > COUNT_W'(PHYS_SLOTS))
        begin
            eff_depth = COUNT_W'(PHYS_SLOTS);
        end
        else
        begin
            eff_depth = depth_reg;
        end
    end

    assign advance  = !rsp_valid_reg || rsp.ready;
    assign req.ready = !norm_busy_reg && (!stage_valid_reg || advance);
    assign req_take = req.valid && req.ready;

    always_comb
    begin
        for (int i = 0; i < MAP_W; i++)
        begin
            depth_mask[i] = (COUNT_W'(i) < eff_depth);
            start_mask[i] = (SLOT_W'(i) >= start_mod_reg);
        end
    end

    // Search upward from the start pointer first, then wrap to slot zero
    assign free_map   = ~busy_map_reg & depth_mask;
    assign upper_free = free_map & start_mask;
    assign pick       = (|upper_free) ? lowest_set(upper_free) : lowest_set(free_map);
    assign pick_inc   = {1'b0, pick} + COUNT_W'(1);
    assign rel_ok     = ({1'b0, stage_rel_reg} < COUNT_W'(PHYS_SLOTS))
                        && busy_map_reg[stage_rel_reg];

    always_comb
    begin
        depth_next       = depth_reg;
        busy_map_next    = busy_map_reg;
        scan_start_next  = scan_start_reg;
        start_mod_next   = start_mod_reg;
        norm_busy_next   = norm_busy_reg;
        busy_count_next  = busy_count_reg;
        stage_valid_next = stage_valid_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;

        if (cfg_write && (paddr[2] == REG_QUEUE_DEPTH))
        begin
            depth_next     = pwdata[COUNT_W-1:0];
            start_mod_next = scan_start_reg;
            norm_busy_next = 1'b1;
        end
        else if (norm_busy_reg)
        begin
            // Reduce the start pointer modulo the new depth
            if ({1'b0, start_mod_reg} >= eff_depth)
            begin
                start_mod_next = SLOT_W'({1'b0, start_mod_reg} - eff_depth);
            end
            else
            begin
                norm_busy_next = 1'b0;
            end
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (stage_valid_reg && advance)
        begin
            rsp_valid_next = 1'b1;
            slot_next      = '0;
            if (stage_op_reg == OP_ALLOC)
            begin
                if (|free_map)
                begin
                    busy_map_next[pick] = 1'b1;
                    busy_count_next     = busy_count_reg + COUNT_W'(1);
                    slot_next           = pick;
                    status_next         = ST_GRANTED;
                    if (pick_inc >= eff_depth)
                    begin
                        scan_start_next = '0;
                    end
                    else
                    begin
                        scan_start_next = pick_inc[SLOT_W-1:0];
                    end
                    start_mod_next = scan_start_next;
                end
                else
                begin
                    status_next = ST_ALL_BUSY;
                end
            end
            else
            begin
                if (rel_ok)
                begin
                    busy_map_next[stage_rel_reg] = 1'b0;
                    busy_count_next              = busy_count_reg - COUNT_W'(1);
                    status_next                  = ST_RELEASED;
                end
                else
                begin
                    status_next = ST_BAD_RELEASE;
                end
            end
        end

        if (req_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg       <= DEPTH_RESET;
            busy_map_reg    <= '0;
            scan_start_reg  <= '0;
            start_mod_reg   <= '0;
            norm_busy_reg   <= 1'b0;
            busy_count_reg  <= '0;
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            depth_reg       <= depth_next;
            busy_map_reg    <= busy_map_next;
            scan_start_reg  <= scan_start_next;
            start_mod_reg   <= start_mod_next;
            norm_busy_reg   <= norm_busy_next;
            busy_count_reg  <= busy_count_next;
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers: load on a taken beat or an advancing result
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            stage_op_reg  <= req.opcode;
            stage_rel_reg <= req.release_slot;
        end
        if (stage_valid_reg && advance)
        begin
            status_reg      <= status_next;
            slot_reg        <= slot_next;
            outstanding_reg <= busy_count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.slot        = slot_reg;
    assign rsp.outstanding = outstanding_reg;

endmodule

`default_nettype wire
